// ----- design/mcsm_pkg.sv -----
// Shared types, constants and codes of the staleness monitor.
`timescale 1ns / 1ps
package mcsm_pkg;

	localparam int NUM_CHANNELS   = 4;
	localparam int CH_BITS        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int TIME_BITS      = 48;
	localparam int CHANNEL_BITS   = 2;
	localparam int LEVEL_BITS     = 2;
	localparam int TIMEOUT_BITS   = 32;
	localparam int MASK_BITS      = 4;
	localparam int RATE_BITS      = 30;
	localparam int COUNT_BITS     = 32;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	// Width of the divider remainder and of the compares around it
	localparam int DIV_W     = RATE_BITS + 1;
	localparam int DIV_CMP_W = (TIME_BITS > DIV_W) ? TIME_BITS : DIV_W;
	localparam int STEP_BITS = $clog2(RATE_BITS + 1);
	localparam int TO_CMP_W  = (TIME_BITS > TIMEOUT_BITS) ? TIME_BITS : TIMEOUT_BITS;

	localparam logic [RATE_BITS-1:0]    RATE_NUMERATOR = RATE_BITS'(1000000000);
	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET  = TIMEOUT_BITS'(1000000);

	localparam logic CMD_ARRIVAL  = 1'b0;
	localparam logic CMD_EVALUATE = 1'b1;

	localparam logic [LEVEL_BITS-1:0] LEVEL_UNKNOWN = 2'd0;
	localparam logic [LEVEL_BITS-1:0] LEVEL_OK      = 2'd1;
	localparam logic [LEVEL_BITS-1:0] LEVEL_WARN    = 2'd2;
	localparam logic [LEVEL_BITS-1:0] LEVEL_ERROR   = 2'd3;

	// Register indexes: timeouts occupy 0 .. NUM_TIMEOUT_REGS-1
	localparam int NUM_TIMEOUT_REGS = 4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MISSING_MASK = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_MASK  = 3'd5;

	typedef struct packed {
		logic [TIME_BITS-1:0] last_time;
		logic [TIME_BITS-1:0] min_gap;
	} chan_entry_t;

	typedef struct packed {
		logic                 start;
		logic [TIME_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [RATE_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- design/multi_channel_staleness_monitor_unit.sv -----
// Top level of the multi-channel staleness monitor.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid / in_ready): one request per item. command selects
//   an arrival on `channel` or an evaluate of all channels at time now_us.
//   Output channel (out_valid / out_ready): one verdict per active channel of
//   an evaluate, in ascending channel order, `last` set on the final one.
//   Configuration channel (cfg_valid / cfg_ready, always ready): cfg_index 0..3
//   write the channel timeouts, 4 the missing-level mask, 5 the active mask.
// Sequencing
//   An arrival occupies the block through accept, memory read and write back.
//   An evaluate walks the channels one at a time: an inactive channel is only
//   looked at, an active one is read, aged, checked and handed to the output,
//   with a wait on the serial divider when a rate is reported. The divider,
//   one quotient bit per cycle, makes up most of the walk when rates are reported.
// Reset
//   arst_n clears the flags, the regression counter and the configuration to
//   its reset values; the state memory needs no clearing, since the per-channel
//   flags mark which entries hold data.
// Back-pressure
//   A stalled receiver holds the verdict in the output register; the evaluate
//   walk waits before loading the next one. After the final verdict is loaded
//   the block takes the next request even while that verdict still waits.
module multi_channel_staleness_monitor_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mcsm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mcsm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	// requests
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic [mcsm_pkg::CHANNEL_BITS-1:0]     channel,
	input  logic [mcsm_pkg::TIME_BITS-1:0]        now_us,
	input  logic                                  now_valid,
	// verdicts
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mcsm_pkg::CHANNEL_BITS-1:0]     out_channel,
	output logic [mcsm_pkg::LEVEL_BITS-1:0]       level,
	output logic                                  age_valid,
	output logic [mcsm_pkg::TIME_BITS-1:0]        age_us,
	output logic                                  rate_valid,
	output logic [mcsm_pkg::RATE_BITS-1:0]        rate_millihz,
	output logic [mcsm_pkg::COUNT_BITS-1:0]       regression_count,
	output logic                                  last
);

	localparam int NCH = mcsm_pkg::NUM_CHANNELS;
	localparam int CHB = mcsm_pkg::CH_BITS;
	localparam int TB  = mcsm_pkg::TIME_BITS;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_A_CAL = 3'd1; // arrival: read data back, subtract
	localparam logic [2:0] ST_A_WR  = 3'd2; // arrival: update and write back
	localparam logic [2:0] ST_E_RD  = 3'd3; // evaluate: read current channel
	localparam logic [2:0] ST_E_AGE = 3'd4; // evaluate: age subtraction
	localparam logic [2:0] ST_E_CHK = 3'd5; // evaluate: level, start divider
	localparam logic [2:0] ST_E_DIV = 3'd6; // evaluate: wait for rate
	localparam logic [2:0] ST_E_OUT = 3'd7; // evaluate: hand verdict to output

	logic [2:0] state_q;

	// configuration registers
	logic [mcsm_pkg::TIMEOUT_BITS-1:0] timeout_q [NCH];
	logic [NCH-1:0]                    missing_q;
	logic [NCH-1:0]                    active_q;

	// request registers
	logic [CHB-1:0]                    ch_q;
	logic [TB-1:0]                     now_q;
	logic                              nowv_q;

	// per-channel flags, the valid bits of the state memory
	logic [NCH-1:0]                    rcv_q;
	logic [NCH-1:0]                    two_q;
	logic [mcsm_pkg::COUNT_BITS-1:0]   count_q;

	// subtraction stage
	logic                              back_s1;
	logic [TB-1:0]                     diff_s1;
	logic [TB-1:0]                     gap_s1;

	// verdict under construction
	logic [mcsm_pkg::LEVEL_BITS-1:0]   lvl_q;
	logic                              agev_q;
	logic                              ratev_q;

	// memory and divider hookup
	logic                              rd_en;
	logic [CHB-1:0]                    rd_addr;
	logic                              wr_en;
	mcsm_pkg::chan_entry_t             wr_data;
	mcsm_pkg::chan_entry_t             rd_data;
	mcsm_pkg::div_req_t                div_req;
	mcsm_pkg::div_rsp_t                div_rsp;

	logic                              in_fire;
	logic                              in_ch_ok;
	logic [CHB-1:0]                    in_ch;
	logic                              out_free;
	logic                              out_load;
	logic                              is_last;
	logic [NCH-1:0]                    active_above;
	logic                              use_ch;
	logic                              arr_gap;
	logic [TB-1:0]                     new_gap;
	logic                              count_inc;
	logic                              age_ok;
	logic                              want_rate;
	logic                              out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign in_ch     = CHB'(channel);
	assign in_ch_ok  = (int'(channel) < NCH) && active_q[in_ch];

	// final verdict when no active channel lies above the current one
	assign active_above = active_q >> ch_q;
	assign is_last      = ((active_above >> 1) == '0);

	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == ST_E_OUT) && out_free;

	assign use_ch    = rcv_q[ch_q] && nowv_q;
	assign age_ok    = mcsm_pkg::TO_CMP_W'(diff_s1) <= mcsm_pkg::TO_CMP_W'(timeout_q[ch_q]);
	assign want_rate = two_q[ch_q] && (gap_s1 != '0);

	// arrival gap bookkeeping: a positive gap replaces a larger minimum or becomes the first one
	assign arr_gap = rcv_q[ch_q] && (diff_s1 != '0);
	assign new_gap = (arr_gap && (!two_q[ch_q] || diff_s1 < gap_s1)) ? diff_s1 : gap_s1;

	assign count_inc = ((state_q == ST_A_WR) && rcv_q[ch_q] && back_s1) ||
	                   ((state_q == ST_E_CHK) && use_ch && back_s1);

	// memory access and divider start control
	always_comb begin
		rd_en             = 1'b0;
		rd_addr           = ch_q;
		wr_en             = 1'b0;
		wr_data.last_time = now_q;
		wr_data.min_gap   = new_gap;
		div_req.start     = 1'b0;
		div_req.divisor   = gap_s1;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = in_ch;
				rd_en   = in_fire && (command == mcsm_pkg::CMD_ARRIVAL) && in_ch_ok &&
				          now_valid;
			end
			ST_A_WR: begin
				wr_en = !(rcv_q[ch_q] && back_s1);
			end
			ST_E_RD: begin
				rd_en = active_q[ch_q];
			end
			ST_E_CHK: begin
				div_req.start = use_ch && !back_s1 && want_rate;
			end
			ST_A_CAL, ST_E_AGE, ST_E_DIV, ST_E_OUT: begin
			end
		endcase
	end

	// configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				timeout_q[c] <= mcsm_pkg::TIMEOUT_RESET;
			end
			missing_q <= '0;
			active_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == mcsm_pkg::REG_MISSING_MASK) begin
				missing_q <= NCH'(cfg_data[mcsm_pkg::MASK_BITS-1:0]);
			end else if (cfg_index == mcsm_pkg::REG_ACTIVE_MASK) begin
				active_q <= NCH'(cfg_data[mcsm_pkg::MASK_BITS-1:0]);
			end else begin
				for (int c = 0; c < NCH; c++) begin
					if (c < mcsm_pkg::NUM_TIMEOUT_REGS &&
					    int'(cfg_index) == c) begin
						timeout_q[c] <= cfg_data[mcsm_pkg::TIMEOUT_BITS-1:0];
					end
				end
			end
		end
	end

	// sequencer, flags and the saturating regression counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rcv_q   <= '0;
			two_q   <= '0;
			count_q <= '0;
		end else begin
			if (count_inc && (count_q != '1)) begin
				count_q <= count_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (command == mcsm_pkg::CMD_EVALUATE) begin
							state_q <= ST_E_RD;
						end else if (in_ch_ok && now_valid) begin
							state_q <= ST_A_CAL;
						end
					end
				end
				ST_A_CAL: begin
					state_q <= ST_A_WR;
				end
				ST_A_WR: begin
					// backward stamp: drop the arrival, only count it
					if (!(rcv_q[ch_q] && back_s1)) begin
						rcv_q[ch_q] <= 1'b1;
						if (arr_gap) begin
							two_q[ch_q] <= 1'b1;
						end
					end
					state_q <= ST_IDLE;
				end
				ST_E_RD: begin
					if (active_q[ch_q]) begin
						state_q <= ST_E_AGE;
					end else if (ch_q == CHB'(NCH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_E_AGE: begin
					state_q <= ST_E_CHK;
				end
				ST_E_CHK: begin
					state_q <= div_req.start ? ST_E_DIV : ST_E_OUT;
				end
				ST_E_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_E_OUT;
					end
				end
				ST_E_OUT: begin
					if (out_free) begin
						state_q <= is_last ? ST_IDLE : ST_E_RD;
					end
				end
			endcase
		end
	end

	// request, subtraction and verdict registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q   <= (command == mcsm_pkg::CMD_EVALUATE) ? '0 : in_ch;
			now_q  <= now_us;
			nowv_q <= now_valid;
		end else if ((state_q == ST_E_RD && !active_q[ch_q] && ch_q != CHB'(NCH - 1)) ||
		             (out_load && !is_last)) begin
			// advance to the next channel
			ch_q <= ch_q + 1'b1;
		end
		if (state_q == ST_A_CAL || state_q == ST_E_AGE) begin
			// borrow of the subtraction marks a stamp behind the last arrival
			{back_s1, diff_s1} <= {1'b0, now_q} - {1'b0, rd_data.last_time};
			gap_s1             <= rd_data.min_gap;
		end
		if (state_q == ST_E_CHK) begin
			if (use_ch && !back_s1) begin
				agev_q  <= 1'b1;
				ratev_q <= want_rate;
				if (age_ok) begin
					lvl_q <= mcsm_pkg::LEVEL_OK;
				end else if (missing_q[ch_q]) begin
					lvl_q <= mcsm_pkg::LEVEL_ERROR;
				end else begin
					lvl_q <= mcsm_pkg::LEVEL_WARN;
				end
			end else begin
				lvl_q   <= mcsm_pkg::LEVEL_UNKNOWN;
				agev_q  <= 1'b0;
				ratev_q <= 1'b0;
			end
		end
	end

	// output register: parts the walk from a stalled receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_channel      <= mcsm_pkg::CHANNEL_BITS'(ch_q);
			level            <= lvl_q;
			age_valid        <= agev_q;
			age_us           <= agev_q ? diff_s1 : '0;
			rate_valid       <= ratev_q;
			rate_millihz     <= ratev_q ? div_rsp.quotient : '0;
			regression_count <= count_q;
			last             <= is_last;
		end
	end

	assign out_valid = out_valid_q;

	mcsm_state_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ch_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mcsm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

// ----- design/mcsm_state_ram.sv -----
// Per-channel arrival state memory: one write and one registered read port.
`timescale 1ns / 1ps
module mcsm_state_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [mcsm_pkg::CH_BITS-1:0] wr_addr,
	input  mcsm_pkg::chan_entry_t      wr_data,
	input  logic                       rd_en,
	input  logic [mcsm_pkg::CH_BITS-1:0] rd_addr,
	output mcsm_pkg::chan_entry_t      rd_data
);

	mcsm_pkg::chan_entry_t mem [mcsm_pkg::NUM_CHANNELS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/mcsm_divider.sv -----
// Restoring divider: rate numerator over the minimum gap, one quotient bit a cycle.
`timescale 1ns / 1ps
module mcsm_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mcsm_pkg::div_req_t    req,
	output mcsm_pkg::div_rsp_t    rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [mcsm_pkg::STEP_BITS-1:0]      step_q;
	logic [mcsm_pkg::TIME_BITS-1:0]      divisor_q;
	logic [mcsm_pkg::DIV_W-1:0]          rem_q;
	logic [mcsm_pkg::RATE_BITS-1:0]      quo_q;
	logic [mcsm_pkg::DIV_W-1:0]          trial;
	logic                                fits;

	// shift in the next numerator bit, try to subtract
	assign trial = {rem_q[mcsm_pkg::DIV_W-2:0], quo_q[mcsm_pkg::RATE_BITS-1]};
	assign fits  = mcsm_pkg::DIV_CMP_W'(trial) >= mcsm_pkg::DIV_CMP_W'(divisor_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == mcsm_pkg::STEP_BITS'(mcsm_pkg::RATE_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			rem_q     <= '0;
			quo_q     <= mcsm_pkg::RATE_NUMERATOR;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - mcsm_pkg::DIV_W'(divisor_q)) : trial;
			quo_q <= {quo_q[mcsm_pkg::RATE_BITS-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- design/mcsm_checker.sv -----
// Port-level checks of the verdict channel, bound to the top level.
`timescale 1ns / 1ps
module mcsm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [mcsm_pkg::CHANNEL_BITS-1:0]   out_channel,
	input logic [mcsm_pkg::LEVEL_BITS-1:0]     level,
	input logic                                age_valid,
	input logic [mcsm_pkg::TIME_BITS-1:0]      age_us,
	input logic                                rate_valid,
	input logic [mcsm_pkg::RATE_BITS-1:0]      rate_millihz,
	input logic [mcsm_pkg::COUNT_BITS-1:0]     regression_count,
	input logic                                last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_channel) &&
		$stable(level) && $stable(age_us) && $stable(rate_millihz) && $stable(last))
		else $error("verdict changed while stalled");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (level == mcsm_pkg::LEVEL_UNKNOWN) |-> !age_valid && !rate_valid)
		else $error("unknown verdict carries a measurement");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (age_valid || (age_us == '0)) && (rate_valid || (rate_millihz == '0)))
		else $error("unmeasured field not zero");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid || (regression_count >= $past(regression_count)))
		else $error("regression count went down");

endmodule

bind multi_channel_staleness_monitor_unit mcsm_checker u_chk (.*);

// ----- tb/sv/multi_channel_staleness_monitor_unit_test.sv -----
// Testbench for the staleness monitor: verdict predictor, request and verdict drivers.
`timescale 1ns / 1ps
module multi_channel_staleness_monitor_unit_test;
	import mcsm_pkg::*;

	// Generous bound on the whole run, in ns
	localparam longint LIMIT_NS = 2000000;
	// Cycles to let pass after the last verdict
	localparam int SETTLE_CYCLES = 200;
	// Length of the long receiver hold-off
	localparam int HOLD_CYCLES = 400;
	// Timeout registers take indexes 0 .. NUM_TIMEOUT_REGS-1
	localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_BASE = '0;

	// One verdict as it leaves the block
	typedef struct packed {
		logic [CHANNEL_BITS-1:0] ch;
		logic [LEVEL_BITS-1:0]   level;
		logic                    age_valid;
		logic [TIME_BITS-1:0]    age;
		logic                    rate_valid;
		logic [RATE_BITS-1:0]    rate;
		logic [COUNT_BITS-1:0]   count;
		logic                    last;
	} verdict_t;

	// Keeps its own copy of the channel state and the registers, works out the
	// verdicts of every accepted request and checks the block's verdicts in order.
	class staleness_scoreboard;
		logic [TIMEOUT_BITS-1:0] timeout_us [NUM_CHANNELS];
		logic [MASK_BITS-1:0]    stale_error_mask;
		logic [MASK_BITS-1:0]    active_chans;
		bit                      seen [NUM_CHANNELS];
		bit                      has_gap [NUM_CHANNELS];
		logic [TIME_BITS-1:0]    last_stamp [NUM_CHANNELS];
		logic [TIME_BITS-1:0]    min_gap [NUM_CHANNELS];
		logic [COUNT_BITS-1:0]   regressions;
		verdict_t                verdicts_due [$];
		int                      errors;
		int                      requests;
		int                      verdicts_seen;

		function new();
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				timeout_us[c] = TIMEOUT_RESET;
				seen[c] = 0;
				has_gap[c] = 0;
				last_stamp[c] = '0;
				min_gap[c] = '0;
			end
			stale_error_mask = '0;
			active_chans = '0;
			regressions = '0;
			errors = 0;
			requests = 0;
			verdicts_seen = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			if (idx < NUM_TIMEOUT_REGS)
				timeout_us[idx] = data;
			else if (idx == REG_MISSING_MASK)
				stale_error_mask = data[MASK_BITS-1:0];
			else if (idx == REG_ACTIVE_MASK)
				active_chans = data[MASK_BITS-1:0];
		endfunction

		function void bump_regressions();
			if (regressions != '1)
				regressions++;
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction

		function void note_request(logic cmd, logic [CHANNEL_BITS-1:0] ch,
				logic [TIME_BITS-1:0] stamp, logic stamp_ok);
			logic [TIME_BITS-1:0] gap;
			verdict_t             v;
			verdict_t             batch [$];
			requests++;
			if (cmd == CMD_ARRIVAL) begin
				if (!active_chans[ch] || !stamp_ok)
					return;
				if (seen[ch] && stamp < last_stamp[ch]) begin
					bump_regressions();
					return;
				end
				if (seen[ch]) begin
					gap = stamp - last_stamp[ch];
					if (gap != '0) begin
						if (!has_gap[ch] || gap < min_gap[ch])
							min_gap[ch] = gap;
						has_gap[ch] = 1;
					end
				end
				last_stamp[ch] = stamp;
				seen[ch] = 1;
				return;
			end
			// Evaluate: one verdict per active channel, ascending order
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				if (!active_chans[c])
					continue;
				v = '0;
				v.ch = CHANNEL_BITS'(c);
				v.level = LEVEL_UNKNOWN;
				if (seen[c] && stamp_ok) begin
					if (stamp < last_stamp[c]) begin
						bump_regressions();
					end else begin
						v.age_valid = 1;
						v.age = stamp - last_stamp[c];
						if (v.age <= TIME_BITS'(timeout_us[c]))
							v.level = LEVEL_OK;
						else
							v.level = stale_error_mask[c] ? LEVEL_ERROR : LEVEL_WARN;
						if (has_gap[c] && min_gap[c] != '0) begin
							v.rate_valid = 1;
							v.rate = RATE_BITS'(TIME_BITS'(RATE_NUMERATOR) / min_gap[c]);
						end
					end
				end
				v.count = regressions;
				batch.insert(batch.size(), v);
			end
			if (batch.size() > 0)
				batch[batch.size()-1].last = 1;
			foreach (batch[i])
				verdicts_due.insert(verdicts_due.size(), batch[i]);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			verdicts_seen++;
			if (verdicts_due.size() == 0) begin
				$error("verdict for channel %0d with none outstanding", got.ch);
				errors++;
				return;
			end
			want = verdicts_due.pop_front();
			compare_field("out_channel", 64'(want.ch), 64'(got.ch));
			compare_field("level", 64'(want.level), 64'(got.level));
			compare_field("age_valid", 64'(want.age_valid), 64'(got.age_valid));
			compare_field("age_us", 64'(want.age), 64'(got.age));
			compare_field("rate_valid", 64'(want.rate_valid), 64'(got.rate_valid));
			compare_field("rate_millihz", 64'(want.rate), 64'(got.rate));
			compare_field("regression_count", 64'(want.count), 64'(got.count));
			compare_field("last", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      command;
	logic [CHANNEL_BITS-1:0]   channel;
	logic [TIME_BITS-1:0]      now_us;
	logic                      now_valid;
	logic                      out_valid;
	logic                      out_ready;
	logic [CHANNEL_BITS-1:0]   out_channel;
	logic [LEVEL_BITS-1:0]     level;
	logic                      age_valid;
	logic [TIME_BITS-1:0]      age_us;
	logic                      rate_valid;
	logic [RATE_BITS-1:0]      rate_millihz;
	logic [COUNT_BITS-1:0]     regression_count;
	logic                      last;

	staleness_scoreboard sb;

	// Sender pacing: bursts of random length, random gaps between them
	int                   burst_left;
	bit                   no_gaps;
	// Running time base for well-formed stamps
	logic [TIME_BITS-1:0] clock_now;
	// Hold-off handshake between stimulus and receiver
	int                   hold_requests;
	int                   hold_served;
	int                   config_sets;

	multi_channel_staleness_monitor_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.channel          (channel),
		.now_us           (now_us),
		.now_valid        (now_valid),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_channel      (out_channel),
		.level            (level),
		.age_valid        (age_valid),
		.age_us           (age_us),
		.rate_valid       (rate_valid),
		.rate_millihz     (rate_millihz),
		.regression_count (regression_count),
		.last             (last)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Hard stop: a hung handshake ends here
	initial begin
		#(LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	// Sample verdicts at the rising edge, as the block sees the handshake
	always @(posedge clk) begin : watch_verdicts
		verdict_t got;
		if (arst_n && out_valid && out_ready) begin
			got.ch = out_channel;
			got.level = level;
			got.age_valid = age_valid;
			got.age = age_us;
			got.rate_valid = rate_valid;
			got.rate = rate_millihz;
			got.count = regression_count;
			got.last = last;
			sb.check_verdict(got);
		end
	end

	// Receiver: switch among random stall patterns; on request, hold
	// off completely for a long stretch so the block backs up into its input
	initial begin : receiver
		int mode;
		int left;
		out_ready = 0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				out_ready = 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_served++;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 120);
			end
			left--;
			case (mode)
				0: out_ready = 1;
				1: out_ready = $urandom_range(0, 1);
				2: out_ready = (left % 4 == 0);
				default: out_ready = ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	function automatic logic [TIME_BITS-1:0] any_stamp();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [TIMEOUT_BITS-1:0] pick_timeout();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return TIMEOUT_BITS'($urandom_range(0, 4000));
			default: return TIMEOUT_BITS'($urandom);
		endcase
	endfunction

	// Offer one request; valid stays high until the block takes it. The next
	// call either replaces the payload or drops valid at the following falling edge.
	task automatic send_request(input logic cmd, input logic [CHANNEL_BITS-1:0] ch,
			input logic [TIME_BITS-1:0] stamp, input logic stamp_ok);
		int gap;
		gap = 0;
		if (!no_gaps) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 12);
				burst_left = $urandom_range(1, 10);
			end else begin
				burst_left--;
			end
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		command = cmd;
		channel = ch;
		now_us = stamp;
		now_valid = stamp_ok;
		do @(posedge clk); while (!in_ready);
		sb.note_request(cmd, ch, stamp, stamp_ok);
	endtask

	// Drop valid, wait until every predicted verdict has arrived, then let
	// any arrival still in flight finish
	task automatic wait_for_verdicts();
		@(negedge clk);
		in_valid = 0;
		while (sb.pending() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic program_regs(input logic [TIMEOUT_BITS-1:0] t0,
			input logic [TIMEOUT_BITS-1:0] t1,
			input logic [TIMEOUT_BITS-1:0] t2, input logic [TIMEOUT_BITS-1:0] t3,
			input logic [MASK_BITS-1:0] stale_err, input logic [MASK_BITS-1:0] act);
		logic [TIMEOUT_BITS-1:0] to [NUM_TIMEOUT_REGS];
		to[0] = t0;
		to[1] = t1;
		to[2] = t2;
		to[3] = t3;
		for (int c = 0; c < NUM_TIMEOUT_REGS; c++)
			write_reg(REG_TIMEOUT_BASE + CFG_INDEX_BITS'(c), CFG_DATA_BITS'(to[c]));
		write_reg(REG_MISSING_MASK, CFG_DATA_BITS'(stale_err));
		write_reg(REG_ACTIVE_MASK, CFG_DATA_BITS'(act));
		config_sets++;
	endtask

	// Mostly well-formed traffic: non-decreasing stamps, arrivals and evaluates; the
	// rest is backward stamps, unmeasurable stamps and evaluates at random times
	task automatic random_request(input int step_max);
		int                      r;
		logic [CHANNEL_BITS-1:0] ch;
		r = $urandom_range(0, 99);
		ch = CHANNEL_BITS'($urandom_range(0, NUM_CHANNELS - 1));
		if (r < 60) begin
			clock_now += TIME_BITS'($urandom_range(0, step_max));
			send_request(CMD_ARRIVAL, ch, clock_now, 1);
		end else if (r < 82) begin
			clock_now += TIME_BITS'($urandom_range(0, step_max));
			send_request(CMD_EVALUATE, ch, clock_now, 1);
		end else if (r < 90) begin
			send_request(CMD_ARRIVAL, ch, clock_now - TIME_BITS'($urandom_range(1, 400)), 1);
		end else if (r < 95) begin
			send_request(($urandom_range(0, 1) == 1) ? CMD_EVALUATE : CMD_ARRIVAL,
				ch, any_stamp(), 0);
		end else begin
			send_request(CMD_EVALUATE, ch, any_stamp(), 1);
		end
	endtask

	initial begin : stimulus
		int step_max;
		sb = new();
		burst_left = 0;
		no_gaps = 0;
		clock_now = TIME_BITS'(1000);
		hold_requests = 0;
		hold_served = 0;
		config_sets = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		command = CMD_ARRIVAL;
		channel = '0;
		now_us = '0;
		now_valid = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;

		// Reset settings: no channel active, so evaluate yields nothing and
		// the arrival is ignored
		send_request(CMD_EVALUATE, 2'd0, TIME_BITS'(5), 1);
		send_request(CMD_ARRIVAL, 2'd0, TIME_BITS'(5), 1);
		wait_for_verdicts();

		// Directed: timeout extremes, mixed stale levels, all channels active
		program_regs(32'd250, '0, '1, 32'd1000, 4'b0101, 4'hF);
		send_request(CMD_EVALUATE, 2'd3, TIME_BITS'(10), 1);     // nothing received yet
		send_request(CMD_ARRIVAL, 2'd0, TIME_BITS'(100), 1);
		send_request(CMD_ARRIVAL, 2'd0, TIME_BITS'(100), 1);     // equal stamp
		send_request(CMD_ARRIVAL, 2'd0, TIME_BITS'(350), 1);     // gap of 250
		send_request(CMD_ARRIVAL, 2'd0, TIME_BITS'(50), 1);      // backward
		send_request(CMD_ARRIVAL, 2'd1, TIME_BITS'(123), 0);     // unmeasurable
		send_request(CMD_ARRIVAL, 2'd1, TIME_BITS'(400), 1);
		send_request(CMD_ARRIVAL, 2'd2, '0, 1);
		send_request(CMD_ARRIVAL, 2'd2, TIME_BITS'(1), 1);       // gap of one: peak rate
		send_request(CMD_ARRIVAL, 2'd3, TIME_BITS'(1000), 1);
		send_request(CMD_EVALUATE, 2'd0, TIME_BITS'(600), 1);    // age equals timeout on 0
		send_request(CMD_EVALUATE, 2'd0, TIME_BITS'(600), 0);    // unmeasurable evaluate
		send_request(CMD_EVALUATE, 2'd0, TIME_BITS'(601), 1);    // just past timeout
		send_request(CMD_ARRIVAL, 2'd3, 48'h8000_0000_0000, 1);
		send_request(CMD_ARRIVAL, 2'd3, 48'h8000_0000_0001, 1);
		send_request(CMD_EVALUATE, 2'd1, '1, 1);                 // largest stamp
		send_request(CMD_EVALUATE, 2'd2, '0, 1);                 // backward on every channel
		wait_for_verdicts();

		// Long receiver hold-off while the sender keeps offering evaluates
		hold_requests++;
		no_gaps = 1;
		repeat (6) send_request(CMD_EVALUATE, 2'd0, TIME_BITS'(700), 1);
		no_gaps = 0;
		// Pause the sender until every verdict is in
		wait_for_verdicts();

		// Random phases, each under fresh settings; the third runs without gaps
		for (int phase = 0; phase < 4; phase++) begin
			program_regs(pick_timeout(), pick_timeout(), pick_timeout(), pick_timeout(),
				(phase == 0) ? 4'h0 : (phase == 1) ? 4'hF : MASK_BITS'($urandom_range(0, 15)),
				(phase == 0) ? 4'hF : MASK_BITS'($urandom_range(1, 15)));
			no_gaps = (phase == 2);
			step_max = $urandom_range(1, 3000);
			repeat (50) random_request(step_max);
			no_gaps = 0;
			wait_for_verdicts();
		end

		// Arrival at the largest stamp, then evaluate at the same time
		program_regs(TIMEOUT_RESET, TIMEOUT_RESET, TIMEOUT_RESET, TIMEOUT_RESET, 4'h0, 4'hF);
		send_request(CMD_ARRIVAL, 2'd1, '1, 1);
		send_request(CMD_EVALUATE, 2'd1, '1, 1);
		wait_for_verdicts();

		$display("Summary: %0d requests under %0d register settings, %0d verdicts checked.",
			sb.requests, config_sets, sb.verdicts_seen);
		$display("Summary: %0d clock regressions predicted, %s %0d time(s).",
			sb.regressions, "long receiver hold-off served", hold_served);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
